@@ hw/rtl/dhfk_pkg.sv @@
// ----------------------------------------------------------------------------
// dhfk_pkg
// shared types, constants and the sine table builder for the kinematics chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dhfk_pkg;

  // input transaction layout
  localparam int IN_DATA_W = 56;
  localparam int ANGLE_W   = 10;
  localparam int LEN_W     = 16;
  localparam int DEG_W     = 9;
  localparam int ROM_IDX_W = 7;

  // accumulator geometry: top three rows of a 4x4 transform
  localparam int ACC_ROWS = 3;
  localparam int ACC_COLS = 4;

  // pi in q.31
  localparam logic [63:0] PI_Q31 = 64'd6746518852;

  typedef logic [31:0] sin_tab_t [0:90];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XFORM,
    ST_READ,
    ST_MSTART,
    ST_MWAIT,
    ST_DONE
  } dhfk_state_t;

  // restoring division, only used while the sine table is elaborated
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, dvs}) begin
        rem  = rem - {1'b0, dvs};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(k deg), k = 0..90, taylor series in q.31 then rounded to q.frac
  function automatic sin_tab_t build_sin_rom(input int frac);
    sin_tab_t           tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic [63:0]        den;
    logic signed [63:0] s;
    for (int k = 0; k <= 90; k++) begin
      x  = udiv64(64'(k) * PI_Q31 + 64'd90, 64'd180);
      x2 = (x * x + (64'd1 << 30)) >> 31;
      t  = x;
      s  = $signed(x);
      for (int n = 1; n < 20; n++) begin
        den = 64'(2 * n) * 64'(2 * n + 1);
        t   = udiv64(((t * x2 + (64'd1 << 30)) >> 31) + (den >> 1), den);
        if ((n & 1) == 1) begin
          s = s - $signed(t);
        end else begin
          s = s + $signed(t);
        end
      end
      if (s < 64'sd0) begin
        s = 64'sd0;
      end
      if (s > 64'sd2147483648) begin
        s = 64'sd2147483648;
      end
      tab[k] = 32'((s + (64'sd1 <<< (30 - frac))) >>> (31 - frac));
    end
    tab[90] = 32'd1 << frac;
    return tab;
  endfunction

endpackage

@@ hw/rtl/dh_forward_kinematics_chain.sv @@
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain
// chained link transforms, running 3x4 product kept in a small ram
// ----------------------------------------------------------------------------
// links are taken one at a time: a new link is accepted only after the previous
//   result has been loaded for output; every entry is one dot product on the single
//   shared multiply-accumulate, built from 8 partial products
// reset: synchronous active low; the running product reads as identity and
//   no result is pending; the ram itself needs no clearing
`timescale 1ns / 1ps

module dh_forward_kinematics_chain #(
  parameter int FRAC_BITS   = 16,
  parameter int ENTRY_WIDTH = 40
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // link in
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // theta_deg[9:0], alpha_deg[19:10], offset_d[35:20], length_a[51:36], zero pad
  input  logic [dhfk_pkg::IN_DATA_W-1:0]         in_tdata,
  input  logic                                   in_tlast,   // last_link
  // product out
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // r00, r01, r02, r03, r10, r11, r12, r13, r20, r21, r22, r23, zero pad
  output logic [((12*ENTRY_WIDTH+7)/8)*8-1:0]    out_tdata
);

  localparam int TW     = FRAC_BITS + 17;   // widest link transform entry (a*cos)
  localparam int EW     = ENTRY_WIDTH;
  localparam int NENT   = dhfk_pkg::ACC_ROWS * dhfk_pkg::ACC_COLS;
  localparam int OUT_W  = ((NENT * EW + 7) / 8) * 8;
  localparam logic signed [EW-1:0] ONE_Q = EW'(1) <<< FRAC_BITS;

  dhfk_pkg::dhfk_state_t state_r, state_nxt;

  logic                 in_acc;
  logic                 xf_done, mac_start, mac_done, ram_we, rd_issue, out_load, out_free;
  logic signed [TW-1:0] tr [4][4];
  logic signed [TW-1:0] b_sel [4];
  logic signed [EW-1:0] row_q_r [4];
  logic signed [EW-1:0] mac_res;
  logic [EW-1:0]        ram_rdata;
  logic [1:0]           row_r, col_r, rd_k_r;
  logic [2:0]           rd_cnt_r;
  logic                 rd_vld_r;
  logic                 ident_r;    // whole running product reads as identity
  logic                 last_r;
  logic                 out_valid_r;
  logic signed [EW-1:0] nm_r  [dhfk_pkg::ACC_ROWS][dhfk_pkg::ACC_COLS];
  logic signed [EW-1:0] out_r [dhfk_pkg::ACC_ROWS][dhfk_pkg::ACC_COLS];

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // link transform builder
  dhfk_xform #(
    .FRAC_BITS (FRAC_BITS),
    .TW        (TW)
  ) u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (in_acc),
    .theta_i ($signed(in_tdata[9:0])),
    .alpha_i ($signed(in_tdata[19:10])),
    .d_i     ($signed(in_tdata[35:20])),
    .a_i     ($signed(in_tdata[51:36])),
    .done_o  (xf_done),
    .tr_o    (tr)
  );

  // column of the link transform for the entry in progress
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      b_sel[k] = tr[k][col_r];
    end
  end

  dhfk_mac #(
    .FRAC_BITS (FRAC_BITS),
    .EW        (EW),
    .TW        (TW)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mac_start),
    .a_i     (row_q_r),
    .b_i     (b_sel),
    .done_o  (mac_done),
    .res_o   (mac_res)
  );

  // running product, row-major; a row is read out completely before any
  // entry of it is written back, so no forwarding is needed
  dhfk_ram #(
    .WIDTH (EW),
    .DEPTH (NENT)
  ) u_ram (
    .clk     (clk),
    .we_i    (ram_we),
    .waddr_i ({row_r, col_r}),
    .wdata_i (mac_res),
    .raddr_i ({row_r, rd_cnt_r[1:0]}),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dhfk_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = dhfk_pkg::ST_XFORM;
        end
      end
      dhfk_pkg::ST_XFORM: begin
        if (xf_done) begin
          state_nxt = dhfk_pkg::ST_READ;
        end
      end
      dhfk_pkg::ST_READ: begin
        if (rd_cnt_r == 3'd4) begin
          state_nxt = dhfk_pkg::ST_MSTART;
        end
      end
      dhfk_pkg::ST_MSTART: begin
        state_nxt = dhfk_pkg::ST_MWAIT;
      end
      dhfk_pkg::ST_MWAIT: begin
        if (mac_done) begin
          if (col_r != 2'd3) begin
            state_nxt = dhfk_pkg::ST_MSTART;
          end else if (row_r == 2'd2) begin
            state_nxt = dhfk_pkg::ST_DONE;
          end else begin
            state_nxt = dhfk_pkg::ST_READ;
          end
        end
      end
      dhfk_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = dhfk_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dhfk_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    rd_issue  = 1'b0;
    mac_start = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      dhfk_pkg::ST_IDLE:   in_tready = 1'b1;
      dhfk_pkg::ST_READ:   rd_issue  = (rd_cnt_r < 3'd4);
      dhfk_pkg::ST_MSTART: mac_start = 1'b1;
      dhfk_pkg::ST_MWAIT:  ram_we    = mac_done;
      dhfk_pkg::ST_DONE:   out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dhfk_pkg::ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      rd_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      ident_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_issue;
      if (state_r == dhfk_pkg::ST_XFORM && xf_done) begin
        row_r    <= '0;
        col_r    <= '0;
        rd_cnt_r <= '0;
      end else if (rd_issue) begin
        rd_cnt_r <= rd_cnt_r + 3'd1;
      end else if (ram_we) begin
        col_r <= col_r + 2'd1;
        if (col_r == 2'd3) begin
          row_r    <= row_r + 2'd1;
          rd_cnt_r <= '0;
        end
      end
      // last link: the result carries the full product, identity only after
      if (out_load) begin
        ident_r     <= last_r;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      last_r <= in_tlast;
    end
    rd_k_r <= rd_cnt_r[1:0];
    if (rd_vld_r) begin
      if (ident_r) begin
        row_q_r[rd_k_r] <= (row_r == rd_k_r) ? ONE_Q : '0;
      end else begin
        row_q_r[rd_k_r] <= $signed(ram_rdata);
      end
    end
    if (ram_we) begin
      nm_r[row_r][col_r] <= mac_res;
    end
    if (out_load) begin
      out_r <= nm_r;
    end
  end

  assign out_tvalid = out_valid_r;

  for (genvar i = 0; i < dhfk_pkg::ACC_ROWS; i++) begin : g_row
    for (genvar j = 0; j < dhfk_pkg::ACC_COLS; j++) begin : g_col
      assign out_tdata[(i * dhfk_pkg::ACC_COLS + j) * EW +: EW] = out_r[i][j];
    end
  end

  if (OUT_W > NENT * EW) begin : g_pad
    assign out_tdata[OUT_W-1:NENT*EW] = '0;
  end

`ifndef SYNTHESIS
  a_xf_done_in_xform : assert property (@(posedge clk) disable iff (!rst_n)
    xf_done |-> state_r == dhfk_pkg::ST_XFORM)
    else $error("transform done outside transform phase");

  a_mac_done_in_wait : assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == dhfk_pkg::ST_MWAIT)
    else $error("mac result arrived with no dot product pending");

  a_row_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dhfk_pkg::ST_READ || state_r == dhfk_pkg::ST_MWAIT) |-> row_r != 2'd3)
    else $error("row counter beyond the stored rows");

  a_load_shows : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid && state_r == dhfk_pkg::ST_IDLE)
    else $error("result load did not reach the output register");
`endif

endmodule

@@ hw/rtl/dhfk_ram.sv @@
// ----------------------------------------------------------------------------
// dhfk_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhfk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_r <= mem[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

@@ hw/rtl/dhfk_xform.sv @@
// ----------------------------------------------------------------------------
// dhfk_xform
// builds one link transform: angle reduction, sine lookup, six products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhfk_xform #(
  parameter int FRAC_BITS = 16,
  parameter int TW        = 33
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start_i,
  input  logic signed [9:0]        theta_i,
  input  logic signed [9:0]        alpha_i,
  input  logic signed [15:0]       d_i,
  input  logic signed [15:0]       a_i,
  output logic                     done_o,
  output logic signed [TW-1:0]     tr_o [4][4]
);

  localparam int SW = FRAC_BITS + 2;
  localparam int MW = (SW > dhfk_pkg::LEN_W + 1) ? SW : dhfk_pkg::LEN_W + 1;
  localparam int PW = 2 * MW;
  localparam dhfk_pkg::sin_tab_t SIN_ROM = dhfk_pkg::build_sin_rom(FRAC_BITS);

  logic [dhfk_pkg::DEG_W-1:0] th_r, al_r;
  logic signed [15:0]         d_r, a_r;
  logic signed [SW-1:0]       st_r, ct_r, sa_r, ca_r;
  logic                       busy_r, pv_r, done_r;
  logic [2:0]                 cnt_r, psel_r;
  logic signed [MW-1:0]       opa, opb;
  logic signed [PW-1:0]       prod_r, qv;
  logic                       issue;
  logic signed [TW-1:0]       t01_r, t02_r, t03_r, t11_r, t12_r, t13_r;

  function automatic logic [dhfk_pkg::DEG_W-1:0] reduce_deg(input logic signed [9:0] v);
    logic signed [10:0] w;
    logic signed [10:0] r;
    w = 11'(v);
    if (w < -11'sd360) begin
      r = w + 11'sd720;
    end else if (w < 11'sd0) begin
      r = w + 11'sd360;
    end else if (w >= 11'sd360) begin
      r = w - 11'sd360;
    end else begin
      r = w;
    end
    return r[dhfk_pkg::DEG_W-1:0];
  endfunction

  function automatic logic [dhfk_pkg::DEG_W-1:0] cos_deg(input logic [dhfk_pkg::DEG_W-1:0] d);
    logic [9:0] s;
    s = {1'b0, d} + 10'd90;
    return (s >= 10'd360) ? 9'(s - 10'd360) : s[dhfk_pkg::DEG_W-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sin_val(input logic [dhfk_pkg::DEG_W-1:0] d);
    logic [dhfk_pkg::ROM_IDX_W-1:0] idx;
    logic                           neg;
    logic signed [SW-1:0]           val;
    if (d <= 9'd90) begin
      idx = d[dhfk_pkg::ROM_IDX_W-1:0];
      neg = 1'b0;
    end else if (d <= 9'd180) begin
      idx = 7'(9'd180 - d);
      neg = 1'b0;
    end else if (d <= 9'd270) begin
      idx = 7'(d - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - d);
      neg = 1'b1;
    end
    val = {1'b0, SIN_ROM[idx][FRAC_BITS:0]};
    return neg ? -val : val;
  endfunction

  assign issue = busy_r && (cnt_r >= 3'd1) && (cnt_r <= 3'd6);

  // operand select for the shared product unit
  always_comb begin
    case (cnt_r)
      3'd1: begin opa = -MW'(st_r); opb = MW'(ca_r); end
      3'd2: begin opa =  MW'(st_r); opb = MW'(sa_r); end
      3'd3: begin opa =  MW'(ct_r); opb = MW'(ca_r); end
      3'd4: begin opa = -MW'(ct_r); opb = MW'(sa_r); end
      3'd5: begin opa =  MW'(a_r);  opb = MW'(ct_r); end
      3'd6: begin opa =  MW'(a_r);  opb = MW'(st_r); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign qv = (prod_r + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 3'd1;
      end
      pv_r   <= issue;
      done_r <= busy_r && (cnt_r == 3'd7);
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      th_r <= reduce_deg(theta_i);
      al_r <= reduce_deg(alpha_i);
      d_r  <= d_i;
      a_r  <= a_i;
    end
    if (busy_r && (cnt_r == 3'd0)) begin
      st_r <= sin_val(th_r);
      ct_r <= sin_val(cos_deg(th_r));
      sa_r <= sin_val(al_r);
      ca_r <= sin_val(cos_deg(al_r));
    end
    if (issue) begin
      prod_r <= opa * opb;
      psel_r <= cnt_r - 3'd1;
    end
    if (pv_r) begin
      case (psel_r)
        3'd0: t01_r <= TW'(qv);
        3'd1: t02_r <= TW'(qv);
        3'd2: t11_r <= TW'(qv);
        3'd3: t12_r <= TW'(qv);
        3'd4: t03_r <= TW'(prod_r);
        3'd5: t13_r <= TW'(prod_r);
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        tr_o[r][c] = '0;
      end
    end
    tr_o[0][0] = TW'(ct_r);
    tr_o[0][1] = t01_r;
    tr_o[0][2] = t02_r;
    tr_o[0][3] = t03_r;
    tr_o[1][0] = TW'(st_r);
    tr_o[1][1] = t11_r;
    tr_o[1][2] = t12_r;
    tr_o[1][3] = t13_r;
    tr_o[2][1] = TW'(sa_r);
    tr_o[2][2] = TW'(ca_r);
    tr_o[2][3] = TW'(d_r) <<< FRAC_BITS;
    tr_o[3][3] = TW'(1) <<< FRAC_BITS;
  end

  assign done_o = done_r;

endmodule

@@ hw/rtl/dhfk_mac.sv @@
// ----------------------------------------------------------------------------
// dhfk_mac
// shared multiply-accumulate: one four-term dot product, rounded and clamped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhfk_mac #(
  parameter int FRAC_BITS = 16,
  parameter int EW        = 40,
  parameter int TW        = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  logic signed [EW-1:0] a_i [4],
  input  logic signed [TW-1:0] b_i [4],
  output logic                 done_o,
  output logic signed [EW-1:0] res_o
);

  // b operand is split into a low unsigned digit and a high signed digit
  localparam int DW = (TW + 1) / 2;
  localparam int PW = EW + DW + 1;
  localparam int AW = EW + TW + 2;

  logic                 iss_r, v1_r, first1_r, last1_r, dig1_r, last2_r, done_r;
  logic [2:0]           step_r;
  logic [1:0]           term;
  logic signed [TW-1:0] bsel;
  logic signed [DW:0]   dig_v;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r, sh_prod, sum, shv;
  logic signed [EW-1:0] res_r, sat_v;
  logic                 in_range;

  assign term = step_r[2:1];
  assign bsel = b_i[term];

  always_comb begin
    if (step_r[0]) begin
      dig_v = (DW + 1)'($signed(bsel[TW-1:DW]));
    end else begin
      dig_v = {1'b0, bsel[DW-1:0]};
    end
  end

  assign sh_prod = dig1_r ? (AW'(prod_r) <<< DW) : AW'(prod_r);

  // round half up, then clamp to the entry range
  assign sum      = acc_r + (AW'(1) <<< (FRAC_BITS - 1));
  assign shv      = sum >>> FRAC_BITS;
  assign in_range = (&shv[AW-1:EW-1]) || !(|shv[AW-1:EW-1]);

  always_comb begin
    if (in_range) begin
      sat_v = shv[EW-1:0];
    end else if (shv[AW-1]) begin
      sat_v = {1'b1, {(EW - 1){1'b0}}};
    end else begin
      sat_v = {1'b0, {(EW - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r   <= 1'b0;
      step_r  <= '0;
      v1_r    <= 1'b0;
      last2_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      if (start_i) begin
        iss_r  <= 1'b1;
        step_r <= '0;
      end else if (iss_r) begin
        if (step_r == 3'd7) begin
          iss_r <= 1'b0;
        end
        step_r <= step_r + 3'd1;
      end
      v1_r    <= iss_r;
      last2_r <= v1_r && last1_r;
      done_r  <= last2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (iss_r) begin
      prod_r   <= a_i[term] * dig_v;
      first1_r <= (step_r == 3'd0);
      last1_r  <= (step_r == 3'd7);
      dig1_r   <= step_r[0];
    end
    if (v1_r) begin
      acc_r <= (first1_r ? '0 : acc_r) + sh_prod;
    end
    if (last2_r) begin
      res_r <= sat_v;
    end
  end

  assign done_o = done_r;
  assign res_o  = res_r;

endmodule

@@ test/dhfk_chain_checker.sv @@
// ----------------------------------------------------------------------------
// dhfk_chain_checker
// watches the link and pose streams, predicts each pose and compares fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhfk_chain_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [55:0]  in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [479:0] out_tdata,
  output int           fail_count,
  output int           poses_pending,
  output int           poses_checked,
  output int           saturated_entries
);

  localparam int FRAC = 16;
  localparam int EW   = 40;
  localparam logic signed [127:0] ENTRY_MAX = (128'sd1 <<< (EW - 1)) - 128'sd1;
  localparam logic signed [127:0] ENTRY_MIN = -(128'sd1 <<< (EW - 1));

  longint         sine_q [0:90];
  longint         pose [0:11];
  logic [479:0]   pose_q [$];

  // sine of whole degrees in q.16, taylor series in q.31
  initial begin
    logic [63:0] x, x2, t, den;
    longint      s;
    for (int k = 0; k <= 90; k++) begin
      x  = (64'(k) * 64'd6746518852 + 64'd90) / 64'd180;
      x2 = (x * x + (64'd1 << 30)) >> 31;
      t  = x;
      s  = longint'(x);
      for (int n = 1; n < 20; n++) begin
        den = 64'(2 * n) * 64'(2 * n + 1);
        t   = (((t * x2 + (64'd1 << 30)) >> 31) + den / 64'd2) / den;
        if (n % 2 == 1) s = s - longint'(t);
        else s = s + longint'(t);
      end
      if (s < 0) s = 0;
      if (s > 64'sd2147483648) s = 64'sd2147483648;
      sine_q[k] = (s + (64'sd1 <<< (30 - FRAC))) >>> (31 - FRAC);
    end
    sine_q[90] = 64'sd1 <<< FRAC;
  end

  function automatic longint sin_of(int deg);
    if (deg <= 90) return sine_q[deg];
    if (deg <= 180) return sine_q[180 - deg];
    if (deg <= 270) return -sine_q[deg - 180];
    return -sine_q[360 - deg];
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic signed [127:0] p;
    p = 128'(signed'(a)) * 128'(signed'(b));
    return longint'((p + 128'sd32768) >>> FRAC);
  endfunction

  function automatic int wrap_deg(logic [9:0] raw);
    int v;
    v = int'($signed(raw)) % 360;
    if (v < 0) v += 360;
    return v;
  endfunction

  task automatic set_identity();
    for (int i = 0; i < 12; i++) pose[i] = (i % 5 == 0) ? (64'sd1 <<< FRAC) : 0;
  endtask

  // multiply the running pose by this link's transform
  task automatic advance_pose(input logic [55:0] link, input logic last);
    int                  th, al;
    longint              ct, st, ca, sa, d, a;
    longint              xf [0:3][0:3];
    longint              nxt [0:11];
    logic signed [127:0] acc, ea, eb;
    logic [479:0]        packed_pose;
    th = wrap_deg(link[9:0]);
    al = wrap_deg(link[19:10]);
    d  = longint'($signed(link[35:20]));
    a  = longint'($signed(link[51:36]));
    st = sin_of(th); ct = sin_of((th + 90) % 360);
    sa = sin_of(al); ca = sin_of((al + 90) % 360);
    xf[0][0] = ct; xf[0][1] = qmul(-st, ca); xf[0][2] = qmul(st, sa);  xf[0][3] = a * ct;
    xf[1][0] = st; xf[1][1] = qmul(ct, ca);  xf[1][2] = qmul(-ct, sa); xf[1][3] = a * st;
    xf[2][0] = 0;  xf[2][1] = sa;            xf[2][2] = ca;            xf[2][3] = d <<< FRAC;
    xf[3][0] = 0;  xf[3][1] = 0;             xf[3][2] = 0;             xf[3][3] = 64'sd1 <<< FRAC;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          ea  = pose[i * 4 + k];
          eb  = xf[k][j];
          acc = acc + ea * eb;
        end
        acc = (acc + 128'sd32768) >>> FRAC;
        if (acc > ENTRY_MAX) begin
          acc = ENTRY_MAX;
          saturated_entries++;
        end else if (acc < ENTRY_MIN) begin
          acc = ENTRY_MIN;
          saturated_entries++;
        end
        nxt[i * 4 + j] = longint'(acc);
      end
    end
    for (int i = 0; i < 12; i++) begin
      pose[i] = nxt[i];
      packed_pose[i * EW +: EW] = nxt[i][EW-1:0];
    end
    pose_q.push_back(packed_pose);
    if (last) set_identity();
  endtask

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    poses_checked = 0;
    saturated_entries = 0;
    set_identity();
  end

  assign poses_pending = pose_q.size();

  always @(posedge clk) begin
    logic [479:0] want;
    if (rst_n) begin
      if (in_tvalid && in_tready) advance_pose(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (pose_q.size() == 0) begin
          report("pose transaction with nothing outstanding");
        end else begin
          want = pose_q.pop_front();
          poses_checked++;
          for (int i = 0; i < 12; i++) begin
            if (out_tdata[i * EW +: EW] !== want[i * EW +: EW])
              report($sformatf("pose %0d entry r%0d%0d got %h want %h", poses_checked,
                               i / 4, i % 4, out_tdata[i * EW +: EW], want[i * EW +: EW]));
          end
        end
      end
    end
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// drives link transactions into the kinematics chain, stalls the pose stream,
// and reports the verdict from the checker's failure count and outstanding poses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_LINKS = 630;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [55:0]  in_tdata;      // theta, alpha, offset_d, length_a, pad
  logic         in_tlast;      // last_link
  logic         out_tvalid;
  logic         out_tready;
  logic [479:0] out_tdata;     // r00 .. r23

  int  fail_count, poses_pending, poses_checked, saturated_entries;
  int  cycle_count;
  int  links_sent;
  int  burst_left;
  bit  hold_off_req;
  bit  hold_off_done;

  dh_forward_kinematics_chain dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  dhfk_chain_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .poses_pending(poses_pending),
    .poses_checked(poses_checked), .saturated_entries(saturated_entries)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: stall pattern is redrawn at random, keyed to the watchdog counter, one long hold-off on request
  initial begin
    int mode;
    out_tready = 1'b0;
    hold_off_done = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_tready <= 1'b0;
        repeat (2500) @(negedge clk);
        hold_off_done = 1'b1;
      end
      if (cycle_count % 64 == 0) mode = $urandom_range(3);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(1) == 0);
        2: out_tready <= ($urandom_range(3) == 0);
        default: out_tready <= ($urandom_range(7) != 0);
      endcase
    end
  end

  // one link transaction; valid stays high inside a burst
  task automatic send_link(input int theta, input int alpha, input int off_d,
                           input int len_a, input bit last);
    int gap;
    bit taken;
    if (burst_left == 0) begin
      gap = $urandom_range(40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, 16'(len_a), 16'(off_d), 10'(alpha), 10'(theta)};
    in_tlast  <= last;
    // ready follows the block state only, so it holds until the next rising edge
    taken = 1'b0;
    while (!taken) begin
      taken = in_tready;
      @(negedge clk);
    end
    burst_left--;
    links_sent++;
  endtask

  function automatic int rand_angle();
    if ($urandom_range(4) == 0) return int'($urandom_range(1023)) - 512;
    if ($urandom_range(4) == 0) return 90 * (int'($urandom_range(8)) - 4);
    return int'($urandom_range(720)) - 360;
  endfunction

  function automatic int rand_len();
    if ($urandom_range(3) == 0) return int'($urandom_range(65535)) - 32768;
    return int'($urandom_range(400)) - 200;
  endfunction

  initial begin
    int chain_len;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    hold_off_req = 1'b0;
    links_sent  = 0;
    burst_left  = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: angle extremes and quadrant edges, length extremes, last_link
    send_link(0, 0, 0, 0, 0);
    send_link(90, 90, 1, 1, 0);
    send_link(180, 180, -1, -1, 0);
    send_link(270, 270, 32767, 32767, 1);
    send_link(359, 359, -32768, -32768, 0);
    send_link(360, -360, 100, -100, 0);
    send_link(-1, -90, 32767, -32768, 1);
    send_link(511, -512, -32768, 32767, 0);
    send_link(-512, 511, 12345, -54, 0);
    send_link(45, 30, 10, 20, 0);
    send_link(-180, -270, -7, 7, 1);
    send_link(1, 89, 0, 32767, 1);
    send_link(91, 179, 32767, 0, 1);
    send_link(-359, 271, -32768, -32768, 0);
    send_link(-511, 181, 32767, 32767, 0);
    send_link(300, -30, -21846, 21845, 1);

    // random kinematic chains; a long hold-off lands partway through
    while (links_sent < 16 + RANDOM_LINKS) begin
      if (links_sent > 200) hold_off_req = 1'b1;
      chain_len = $urandom_range(1, 8);
      for (int i = 0; i < chain_len; i++)
        send_link(rand_angle(), rand_angle(), rand_len(), rand_len(), i == chain_len - 1);
      // one long straight chain drives the z position into saturation
      if (links_sent > 350 && links_sent < 360) begin
        for (int i = 0; i < 280; i++)
          send_link(rand_angle(), 0, 32767, rand_len(), i == 279);
      end
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    wait (poses_pending == 0);
    repeat (300) @(negedge clk);
    if (poses_pending != 0) $display("%0d poses never arrived", poses_pending);

    $display("sent %0d links in random chains with stalls; %0d poses compared",
             links_sent, poses_checked);
    $display("%0d entries predicted at the saturation bounds", saturated_entries);
    if (fail_count == 0 && poses_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/dhfk_pkg.sv
hw/rtl/dhfk_ram.sv
hw/rtl/dhfk_xform.sv
hw/rtl/dhfk_mac.sv
hw/rtl/dh_forward_kinematics_chain.sv
test/dhfk_chain_checker.sv
test/tb_top.sv
